>>> rtl/core/srfpll_pkg.sv
// Shared types, constants and arithmetic helpers for the three-phase SRF PLL.
// Used by the multiply-accumulate unit, the top level and its checker.
package srfpll_pkg;

  // Operand and product widths of the shared multiplier
  localparam int OP_W   = 33;
  localparam int PROD_W = 66;

  // Field widths
  localparam int PU_W    = 17;
  localparam int TRIG_W  = 16;
  localparam int ANGLE_W = 19;
  localparam int OMEGA_W = 28;
  localparam int FI_W    = 32;

  // Operating modes
  localparam logic [1:0] MODE_TRACK = 2'd0;
  localparam logic [1:0] MODE_FIXED = 2'd1;
  localparam logic [1:0] MODE_EXT   = 2'd2;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_MODE,
    REG_PROP_GAIN,
    REG_INT_GAIN,
    REG_STEP_TIME,
    REG_LPF_COEFF,
    REG_NOMINAL
  } cfg_reg_t;

  // Register reset values
  localparam logic [23:0] PROP_GAIN_RST = 24'd117965;
  localparam logic [23:0] INT_GAIN_RST  = 24'd1203146;
  localparam logic [31:0] STEP_TIME_RST = 32'd429497;
  localparam logic [15:0] LPF_COEFF_RST = 16'd655;
  localparam logic [26:0] NOMINAL_RST   = 27'd20588742;

  // Fixed-point constants
  localparam logic [ANGLE_W-1:0] TWO_PI_Q16     = 19'd411775;
  localparam logic [15:0]        THIRD_Q16      = 16'd21845;
  localparam logic [15:0]        INV_SQRT3_Q16  = 16'd37837;
  localparam logic [OP_W-1:0]    INV_TWO_PI_Q32 = 33'd683565276;
  localparam logic [63:0]        HALF_PI_Q30    = 64'd1686629713;

  // Saturation bounds, at product width
  localparam logic signed [PROD_W-1:0] PU_MIN   = -66'sd65536;
  localparam logic signed [PROD_W-1:0] PU_MAX   = 66'sd65535;
  localparam logic signed [PROD_W-1:0] TRIG_MIN = -66'sd16384;
  localparam logic signed [PROD_W-1:0] TRIG_MAX = 66'sd16384;
  localparam logic signed [PROD_W-1:0] OM_MIN   = -66'sd134217728;
  localparam logic signed [PROD_W-1:0] OM_MAX   = 66'sd134217727;
  localparam logic signed [PROD_W-1:0] FI_MIN   = -66'sd2147483648;
  localparam logic signed [PROD_W-1:0] FI_MAX   = 66'sd2147483647;
  localparam logic signed [PROD_W-1:0] ANG_MIN  = 66'sd0;
  localparam logic signed [PROD_W-1:0] ANG_MAX  = 66'sd524287;

  // Sequencer states: one multiply issued in each state from S_TURN to S_INC
  typedef enum logic [4:0] {
    S_IDLE,
    S_TURN,
    S_HD,
    S_LD,
    S_AV,
    S_BV,
    S_AI,
    S_BI,
    S_P1,
    S_P2,
    S_P3,
    S_P4,
    S_P5,
    S_P6,
    S_P7,
    S_P8,
    S_KP,
    S_KI,
    S_LPF,
    S_INC,
    S_FIN,
    S_DONE
  } pll_state_t;

  // Accumulator control of the multiply-accumulate unit
  typedef struct packed {
    logic acc_load;
    logic acc_sub;
  } mac_ctl_t;

  // x / 2^sh, rounded half away from zero
  function automatic logic signed [PROD_W-1:0] round_shift(
    input logic signed [PROD_W-1:0] x,
    input int unsigned              sh
  );
    logic signed [PROD_W-1:0] half;
    logic signed [PROD_W-1:0] tmp;
    half = PROD_W'(1) <<< (sh - 1);
    tmp  = x + half - PROD_W'(x[PROD_W-1]);
    return tmp >>> sh;
  endfunction

  function automatic logic signed [PROD_W-1:0] clamp(
    input logic signed [PROD_W-1:0] x,
    input logic signed [PROD_W-1:0] lo,
    input logic signed [PROD_W-1:0] hi
  );
    logic signed [PROD_W-1:0] r;
    r = x;
    if (x < lo) r = lo;
    else if (x > hi) r = hi;
    return r;
  endfunction

  // Sine of a turn phase (Q0.32) in Q1.14, by a Taylor series on a quarter turn.
  // Evaluated only on constants while the table is built.
  function automatic logic signed [TRIG_W-1:0] rom_sine(input logic [31:0] p);
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    r = {34'd0, p[29:0]};
    if (p[30]) r = 64'h4000_0000 - r;
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    sum  = signed'(x);
    term = ((x * x2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + signed'(term);
    if (sum < 0) sum = 0;
    v = (sum + 64'sd32768) >>> 16;
    if (v > 64'sd16384) v = 64'sd16384;
    if (p[31]) v = -v;
    return TRIG_W'(v);
  endfunction

endpackage

>>> rtl/core/three_phase_srf_pll.sv
// Three-phase synchronous reference frame PLL: Clarke, Park, PI loop,
// frequency filter and angle integrator on one shared multiplier.
// Depends on srfpll_pkg and srfpll_mac.
//
//  channel | signals                                  | role
//  --------+------------------------------------------+---------------------------
//  in      | in_valid, in_ready, volt_*, amp_*, ...   | one sample set per word
//  out     | out_valid, out_ready, alpha_*, ..., omega | one result word per item
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes, always ready
//
// Per item, the states from S_TURN to S_INC issue one multiply each, one per cycle,
// through the shared multiplier; S_FIN then closes the angle update and S_DONE
// hands the result to the output register.
// The result waits in the output register; the next item is accepted while
// it waits. A stalled output holds the sequencer in its last state.
// Synchronous reset clears the sequencer and loop state and presets the config registers.
module three_phase_srf_pll import srfpll_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  // input samples
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [15:0]        volt_a,
  input  logic signed [15:0]        volt_b,
  input  logic signed [15:0]        volt_c,
  input  logic signed [15:0]        amp_a,
  input  logic signed [15:0]        amp_b,
  input  logic signed [15:0]        amp_c,
  input  logic signed [15:0]        sine_ext,
  input  logic signed [15:0]        cosine_ext,
  input  logic                      start_ac,
  // results
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [PU_W-1:0]    alpha_volt,
  output logic signed [PU_W-1:0]    beta_volt,
  output logic signed [PU_W-1:0]    alpha_amp,
  output logic signed [PU_W-1:0]    beta_amp,
  output logic signed [PU_W-1:0]    direct_volt,
  output logic signed [PU_W-1:0]    quad_volt,
  output logic signed [PU_W-1:0]    direct_amp,
  output logic signed [PU_W-1:0]    quad_amp,
  output logic signed [TRIG_W-1:0]  sine_out,
  output logic signed [TRIG_W-1:0]  cosine_out,
  output logic [ANGLE_W-1:0]        angle_out,
  output logic signed [OMEGA_W-1:0] omega_out,
  // configuration
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [31:0]               cfg_data
);

  localparam int ADDR_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int HD_W    = 25 + DEPTH_W;

  pll_state_t state, state_next;

  // configuration registers
  logic [1:0]  mode;
  logic [23:0] prop_gain;
  logic [23:0] int_gain_step;
  logic [31:0] step_time;
  logic [15:0] lpf_coeff;
  logic [26:0] nominal_omega;

  // loop state
  logic [ANGLE_W-1:0]        angle_acc;
  logic signed [FI_W-1:0]    freq_integrator;
  logic signed [OMEGA_W-1:0] omega_filtered;

  // captured input word
  logic signed [15:0] va, vb, vc, ia, ib, ic, sn_in, cs_in;
  logic               start_in;
  logic [ANGLE_W-1:0] angle_prev, angle_wrap;

  // working registers
  logic [23:0]               lo_part;
  logic [HD_W-1:0]           hd_part;
  logic [ADDR_W-1:0]         rom_addr;
  logic [31:0]               rom_word;
  logic signed [TRIG_W-1:0]  sn, cs;
  logic signed [PU_W-1:0]    alpha_v, beta_v, alpha_i, beta_i;
  logic signed [PU_W-1:0]    d_volt, q_volt, d_amp, q_amp;
  logic signed [OMEGA_W-1:0] pi_omega;

  // shared unit
  logic signed [OP_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0] prod, psum;
  mac_ctl_t                 mac_ctl;
  logic                     load_out;

  // combinational helpers
  logic signed [17:0]        sum_al_v, sum_al_i;
  logic signed [16:0]        sum_be_v, sum_be_i;
  logic signed [OMEGA_W-1:0] omega_sel;
  logic signed [OMEGA_W:0]   omega_diff;
  logic [63:0]               turn_sum;
  logic [15:0]               idx_raw, idx;
  logic signed [PU_W-1:0]    clarke_res, park_res;
  logic signed [OMEGA_W-1:0] pi_res, lpf_res;
  logic signed [FI_W-1:0]    fi_res;
  logic signed [PROD_W-1:0]  ang_sum, ang_fix;
  logic [ANGLE_W-1:0]        angle_res;
  logic signed [TRIG_W-1:0]  sn_ext_sat, cs_ext_sat;

  // sine / cosine table, one {sin, cos} word per entry
  logic [31:0] rom_mem [SINE_TABLE_DEPTH];

  for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [31:0] PH = 32'((64'(gi) << 32) / SINE_TABLE_DEPTH);
    assign rom_mem[gi] = {rom_sine(PH), rom_sine(PH + 32'h4000_0000)};
  end

  srfpll_mac u_mac (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .ctl  (mac_ctl),
    .prod (prod),
    .psum (psum)
  );

  assign cfg_ready = 1'b1;

  // Clarke sums of the captured samples
  assign sum_al_v = (18'(va) <<< 1) - 18'(vb) - 18'(vc);
  assign sum_be_v = 17'(vb) - 17'(vc);
  assign sum_al_i = (18'(ia) <<< 1) - 18'(ib) - 18'(ic);
  assign sum_be_i = 17'(ib) - 17'(ic);

  // frequency that drives the filter and the angle
  assign omega_sel  = (mode == MODE_FIXED) ? {1'b0, nominal_omega} : pi_omega;
  assign omega_diff = (OMEGA_W + 1)'(omega_sel) - (OMEGA_W + 1)'(omega_filtered);

  // table index: floor(turn * depth / 2^48) with one wrap
  assign turn_sum = (64'(hd_part) << 24) + prod[63:0];
  assign idx_raw  = turn_sum[63:48];
  assign idx      = (idx_raw >= 16'(SINE_TABLE_DEPTH)) ? idx_raw - 16'(SINE_TABLE_DEPTH)
                                                       : idx_raw;

  // writeback candidates from the product register
  assign clarke_res = PU_W'(clamp(round_shift(prod, 16), PU_MIN, PU_MAX));
  assign park_res   = PU_W'(clamp(round_shift(psum, 14), PU_MIN, PU_MAX));
  assign pi_res     = OMEGA_W'(clamp(round_shift(prod, 15) + PROD_W'(freq_integrator),
                                     OM_MIN, OM_MAX));
  assign fi_res     = FI_W'(clamp(PROD_W'(freq_integrator) + round_shift(prod, 23),
                                  FI_MIN, FI_MAX));
  assign lpf_res    = OMEGA_W'(clamp(PROD_W'(omega_filtered) + round_shift(prod, 16),
                                     OM_MIN, OM_MAX));
  assign ang_sum    = {{(PROD_W - ANGLE_W){1'b0}}, angle_wrap} + round_shift(prod, 32);
  assign ang_fix    = ang_sum[PROD_W-1] ? ang_sum + PROD_W'(TWO_PI_Q16) : ang_sum;
  assign angle_res  = ANGLE_W'(clamp(ang_fix, ANG_MIN, ANG_MAX));
  assign sn_ext_sat = TRIG_W'(clamp(PROD_W'(sn_in), TRIG_MIN, TRIG_MAX));
  assign cs_ext_sat = TRIG_W'(clamp(PROD_W'(cs_in), TRIG_MIN, TRIG_MAX));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_TURN;
      S_TURN:  state_next = S_HD;
      S_HD:    state_next = S_LD;
      S_LD:    state_next = S_AV;
      S_AV:    state_next = S_BV;
      S_BV:    state_next = S_AI;
      S_AI:    state_next = S_BI;
      S_BI:    state_next = S_P1;
      S_P1:    state_next = S_P2;
      S_P2:    state_next = S_P3;
      S_P3:    state_next = S_P4;
      S_P4:    state_next = S_P5;
      S_P5:    state_next = S_P6;
      S_P6:    state_next = S_P7;
      S_P7:    state_next = S_P8;
      S_P8:    state_next = S_KP;
      S_KP:    state_next = S_KI;
      S_KI:    state_next = S_LPF;
      S_LPF:   state_next = S_INC;
      S_INC:   state_next = S_FIN;
      S_FIN:   state_next = S_DONE;
      S_DONE:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // multiplier operands and accumulator control per state
  always_comb begin
    op_a     = '0;
    op_b     = '0;
    mac_ctl  = '0;
    in_ready = (state == S_IDLE);
    load_out = (state == S_DONE) && (!out_valid || out_ready);
    case (state)
      S_TURN: begin
        op_a = {14'd0, angle_acc};
        op_b = INV_TWO_PI_Q32;
      end
      S_HD: begin
        op_a = {8'd0, prod[48:24]};
        op_b = OP_W'(SINE_TABLE_DEPTH);
      end
      S_LD: begin
        op_a = {9'd0, lo_part};
        op_b = OP_W'(SINE_TABLE_DEPTH);
      end
      S_AV: begin
        op_a = OP_W'(sum_al_v);
        op_b = {17'd0, THIRD_Q16};
      end
      S_BV: begin
        op_a = OP_W'(sum_be_v);
        op_b = {17'd0, INV_SQRT3_Q16};
      end
      S_AI: begin
        op_a = OP_W'(sum_al_i);
        op_b = {17'd0, THIRD_Q16};
      end
      S_BI: begin
        op_a = OP_W'(sum_be_i);
        op_b = {17'd0, INV_SQRT3_Q16};
      end
      S_P1: begin
        op_a = OP_W'(alpha_v);
        op_b = OP_W'(cs);
      end
      S_P2: begin
        op_a = OP_W'(beta_v);
        op_b = OP_W'(sn);
        mac_ctl.acc_load = 1'b1;
      end
      S_P3: begin
        op_a = OP_W'(beta_v);
        op_b = OP_W'(cs);
      end
      S_P4: begin
        op_a = OP_W'(alpha_v);
        op_b = OP_W'(sn);
        mac_ctl.acc_load = 1'b1;
      end
      S_P5: begin
        op_a = OP_W'(alpha_i);
        op_b = OP_W'(cs);
        mac_ctl.acc_sub = 1'b1;
      end
      S_P6: begin
        op_a = OP_W'(beta_i);
        op_b = OP_W'(sn);
        mac_ctl.acc_load = 1'b1;
      end
      S_P7: begin
        op_a = OP_W'(beta_i);
        op_b = OP_W'(cs);
      end
      S_P8: begin
        op_a = OP_W'(alpha_i);
        op_b = OP_W'(sn);
        mac_ctl.acc_load = 1'b1;
      end
      S_KP: begin
        op_a = {9'd0, prop_gain};
        op_b = OP_W'(d_volt);
        mac_ctl.acc_sub = 1'b1;
      end
      S_KI: begin
        op_a = {9'd0, int_gain_step};
        op_b = OP_W'(d_volt);
      end
      S_LPF: begin
        op_a = {17'd0, lpf_coeff};
        op_b = OP_W'(omega_diff);
      end
      S_INC: begin
        op_a = OP_W'(omega_sel);
        op_b = {1'b0, step_time};
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  // control, configuration and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      mode            <= MODE_TRACK;
      prop_gain       <= PROP_GAIN_RST;
      int_gain_step   <= INT_GAIN_RST;
      step_time       <= STEP_TIME_RST;
      lpf_coeff       <= LPF_COEFF_RST;
      nominal_omega   <= NOMINAL_RST;
      angle_acc       <= '0;
      freq_integrator <= '0;
      omega_filtered  <= '0;
    end else begin
      state <= state_next;

      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (cfg_valid) begin
        case (cfg_index)
          REG_MODE:      mode          <= cfg_data[1:0];
          REG_PROP_GAIN: prop_gain     <= cfg_data[23:0];
          REG_INT_GAIN:  int_gain_step <= cfg_data[23:0];
          REG_STEP_TIME: step_time     <= cfg_data;
          REG_LPF_COEFF: lpf_coeff     <= cfg_data[15:0];
          REG_NOMINAL:   nominal_omega <= cfg_data[26:0];
          default:       ;
        endcase
      end

      // integrator clears on start in external-angle mode
      if (state == S_LPF) begin
        freq_integrator <= (mode == MODE_EXT && start_in) ? '0 : fi_res;
      end
      if (state == S_INC && mode != MODE_EXT) omega_filtered <= lpf_res;
      if (state == S_FIN && mode != MODE_EXT) angle_acc <= angle_res;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rom_word <= rom_mem[rom_addr];

    if (in_valid && in_ready) begin
      va         <= volt_a;
      vb         <= volt_b;
      vc         <= volt_c;
      ia         <= amp_a;
      ib         <= amp_b;
      ic         <= amp_c;
      sn_in      <= sine_ext;
      cs_in      <= cosine_ext;
      start_in   <= start_ac;
      angle_prev <= angle_acc;
      // wrap test comes before the increment
      angle_wrap <= (angle_acc >= TWO_PI_Q16) ? angle_acc - TWO_PI_Q16 : angle_acc;
    end

    case (state)
      S_HD: lo_part  <= prod[23:0];
      S_LD: hd_part  <= prod[HD_W-1:0];
      S_AV: rom_addr <= ADDR_W'(idx);
      S_BV: alpha_v  <= clarke_res;
      S_AI: begin
        beta_v <= clarke_res;
        sn     <= (mode == MODE_EXT) ? sn_ext_sat : rom_word[31:16];
        cs     <= (mode == MODE_EXT) ? cs_ext_sat : rom_word[15:0];
      end
      S_BI: alpha_i  <= clarke_res;
      S_P1: beta_i   <= clarke_res;
      S_P3: d_volt   <= park_res;
      S_P5: q_volt   <= park_res;
      S_P7: d_amp    <= park_res;
      S_KP: q_amp    <= park_res;
      S_KI: pi_omega <= pi_res;
      default: ;
    endcase

    // output register
    if (load_out) begin
      alpha_volt  <= alpha_v;
      beta_volt   <= beta_v;
      alpha_amp   <= alpha_i;
      beta_amp    <= beta_i;
      direct_volt <= d_volt;
      quad_volt   <= q_volt;
      direct_amp  <= d_amp;
      quad_amp    <= q_amp;
      sine_out    <= sn;
      cosine_out  <= cs;
      angle_out   <= (mode == MODE_EXT) ? '0 : angle_prev;
      omega_out   <= (mode == MODE_EXT) ? pi_omega : omega_filtered;
    end
  end

endmodule

>>> rtl/core/srfpll_mac.sv
// Shared multiply-accumulate unit of the SRF PLL: registered 33x33 signed
// product and one accumulator. Depends on srfpll_pkg.
module srfpll_mac import srfpll_pkg::*; (
  input  logic                     clk,
  input  logic signed [OP_W-1:0]   op_a,
  input  logic signed [OP_W-1:0]   op_b,
  input  mac_ctl_t                 ctl,
  output logic signed [PROD_W-1:0] prod,
  output logic signed [PROD_W-1:0] psum
);

  logic signed [PROD_W-1:0] acc;

  // product register, accumulator loads the previous product
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (ctl.acc_load) begin
      acc <= prod;
    end
  end

  // pairwise sum or difference for the Park terms
  assign psum = ctl.acc_sub ? (acc - prod) : (acc + prod);

endmodule

>>> rtl/core/srfpll_checker.sv
// Port-level assertions for the three-phase SRF PLL, bound to the top level.
// Depends on srfpll_pkg and three_phase_srf_pll.
module srfpll_checker import srfpll_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [TRIG_W-1:0]  sine_out,
  input logic signed [TRIG_W-1:0]  cosine_out,
  input logic [ANGLE_W-1:0]        angle_out,
  input logic signed [OMEGA_W-1:0] omega_out
);

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in progress");

  // a result never shows up the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result word appeared too early");

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result word dropped while stalled");

  // and keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(sine_out) && $stable(cosine_out) &&
                                   $stable(angle_out) && $stable(omega_out)))
    else $error("result payload changed while stalled");

endmodule

bind three_phase_srf_pll srfpll_checker u_checker (.*);

>>> verif/tb_three_phase_srf_pll.sv
`timescale 1ns / 1ps
// Self-checking bench for the three-phase SRF PLL: directed corner words, then
// sweeps of balanced three-phase waves and noise. Depends on srfpll_pkg and the RTL.
module tb_three_phase_srf_pll;
  import srfpll_pkg::*;

  localparam int TABLE_DEPTH = 1024;

  // Spare mode code, decodes as tracking
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Fixed-point constants of the loop
  localparam longint          THIRD_C      = 21845;
  localparam longint          INV_SQRT3_C  = 37837;
  localparam longint          TWO_PI_C     = 411775;
  localparam longint unsigned INV_TWO_PI_C = 64'd683565276;
  localparam longint unsigned HALF_PI_C    = 64'd1686629713;
  localparam logic [31:0]     QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0]     THIRD_TURN   = 32'd1431655765;
  localparam logic [31:0]     GRID_STEP    = 32'd21474836;

  // Field ranges
  localparam longint PU_LO  = -65536;
  localparam longint PU_HI  = 65535;
  localparam longint TRG_LO = -16384;
  localparam longint TRG_HI = 16384;
  localparam longint OM_LO  = -134217728;
  localparam longint OM_HI  = 134217727;
  localparam longint FI_LO  = -64'sd2147483648;
  localparam longint FI_HI  = 64'sd2147483647;
  localparam longint ANG_HI = 524287;

  // Register values after reset
  localparam logic [23:0] DEF_PROP = 24'd117965;
  localparam logic [23:0] DEF_INT  = 24'd1203146;
  localparam logic [31:0] DEF_STEP = 32'd429497;
  localparam logic [15:0] DEF_LPF  = 16'd655;
  localparam logic [26:0] DEF_NOM  = 27'd20588742;

  typedef struct packed {
    logic signed [15:0] volt_a, volt_b, volt_c, amp_a, amp_b, amp_c;
    logic signed [15:0] sine_ext, cosine_ext;
    logic               start_ac;
  } sample_t;

  typedef struct packed {
    logic signed [PU_W-1:0]    alpha_volt, beta_volt, alpha_amp, beta_amp;
    logic signed [PU_W-1:0]    direct_volt, quad_volt, direct_amp, quad_amp;
    logic signed [TRIG_W-1:0]  sine_out, cosine_out;
    logic [ANGLE_W-1:0]        angle_out;
    logic signed [OMEGA_W-1:0] omega_out;
  } frame_t;

  // DUT ports
  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [15:0]        volt_a = '0, volt_b = '0, volt_c = '0;
  logic signed [15:0]        amp_a = '0, amp_b = '0, amp_c = '0;
  logic signed [15:0]        sine_ext = '0, cosine_ext = '0;
  logic                      start_ac = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [PU_W-1:0]    alpha_volt, beta_volt, alpha_amp, beta_amp;
  logic signed [PU_W-1:0]    direct_volt, quad_volt, direct_amp, quad_amp;
  logic signed [TRIG_W-1:0]  sine_out, cosine_out;
  logic [ANGLE_W-1:0]        angle_out;
  logic signed [OMEGA_W-1:0] omega_out;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [2:0]                cfg_index = '0;
  logic [31:0]               cfg_data = '0;

  // Loop state and register copy of the predictor
  longint      ang_acc  = 0;
  longint      freq_acc = 0;
  longint      omega_lp = 0;
  logic [1:0]  cfg_mode = MODE_TRACK;
  logic [23:0] cfg_prop = DEF_PROP;
  logic [23:0] cfg_int  = DEF_INT;
  logic [31:0] cfg_step = DEF_STEP;
  logic [15:0] cfg_lpf  = DEF_LPF;
  logic [26:0] cfg_nom  = DEF_NOM;

  frame_t pending_frames [$];
  int     idle_pct   = 25;
  int     stall_left = 0;
  int     fail_count = 0;
  int     shown      = 0;
  int     sent       = 0;
  int     checked    = 0;
  string  field_names [12] = '{"alpha_volt", "beta_volt", "alpha_amp", "beta_amp",
                               "direct_volt", "quad_volt", "direct_amp", "quad_amp",
                               "sine_out", "cosine_out", "angle_out", "omega_out"};

  three_phase_srf_pll #(.SINE_TABLE_DEPTH(TABLE_DEPTH)) dut (.*);

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- arithmetic

  function automatic longint limit(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // x / 2^sh, rounded half away from zero
  function automatic longint rnd_shift(longint x, int sh);
    longint unsigned half, mag;
    half = 64'd1 << (sh - 1);
    if (x < 0) begin
      mag = unsigned'(-x);
      return -signed'((mag + half) >> sh);
    end
    return signed'((unsigned'(x) + half) >> sh);
  endfunction

  // Q1.14 sine of a Q0.32 turn phase, series on the first quarter
  function automatic longint turn_sine(logic [31:0] p);
    longint unsigned r, x, x2, term;
    longint          total, v;
    int              k;
    r = p[29:0];
    if (p[30]) r = 64'h4000_0000 - r;
    x = (r * HALF_PI_C) >> 30;
    x2 = (x * x) >> 30;
    total = signed'(x);
    term = x;
    for (k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2) total -= signed'(term);
      else total += signed'(term);
    end
    if (total < 0) total = 0;
    v = signed'((unsigned'(total) + 64'd32768) >> 16);
    if (v > 16384) v = 16384;
    return p[31] ? -v : v;
  endfunction

  // Table phase addressed by an angle, quantized to the table depth
  function automatic logic [31:0] table_phase(longint ang);
    longint unsigned turn, idx;
    turn = unsigned'(ang) * INV_TWO_PI_C;
    idx = ((turn * TABLE_DEPTH) >> 48) % TABLE_DEPTH;
    return 32'((idx << 32) / TABLE_DEPTH);
  endfunction

  function automatic void clarke(input longint a, b, c, output longint al, be);
    al = limit(rnd_shift((2 * a - b - c) * THIRD_C, 16), PU_LO, PU_HI);
    be = limit(rnd_shift((b - c) * INV_SQRT3_C, 16), PU_LO, PU_HI);
  endfunction

  // Result word of one sample set; advances the loop state
  function automatic frame_t predict_frame(sample_t s);
    longint      av, bv, ai, bi, sn, cs, vd, vq, id, iq, pi_w, w, w_out, ang_out;
    logic [31:0] ph;
    frame_t      f;
    clarke(s.volt_a, s.volt_b, s.volt_c, av, bv);
    clarke(s.amp_a, s.amp_b, s.amp_c, ai, bi);
    ang_out = 0;
    if (cfg_mode == MODE_EXT) begin
      sn = limit(s.sine_ext, TRG_LO, TRG_HI);
      cs = limit(s.cosine_ext, TRG_LO, TRG_HI);
    end else begin
      ph = table_phase(ang_acc);
      sn = turn_sine(ph);
      cs = turn_sine(ph + QUARTER_TURN);
      ang_out = ang_acc;
    end
    // Park
    vd = limit(rnd_shift(av * cs + bv * sn, 14), PU_LO, PU_HI);
    vq = limit(rnd_shift(bv * cs - av * sn, 14), PU_LO, PU_HI);
    id = limit(rnd_shift(ai * cs + bi * sn, 14), PU_LO, PU_HI);
    iq = limit(rnd_shift(bi * cs - ai * sn, 14), PU_LO, PU_HI);
    // PI on V_d
    pi_w = limit(rnd_shift(longint'(cfg_prop) * vd, 15) + freq_acc, OM_LO, OM_HI);
    if (cfg_mode == MODE_EXT) begin
      w_out = pi_w;
      if (s.start_ac) freq_acc = 0;
      else freq_acc = limit(freq_acc + rnd_shift(longint'(cfg_int) * vd, 23), FI_LO, FI_HI);
    end else begin
      w = (cfg_mode == MODE_FIXED) ? longint'(cfg_nom) : pi_w;
      omega_lp = limit(omega_lp + rnd_shift(longint'(cfg_lpf) * (w - omega_lp), 16),
                       OM_LO, OM_HI);
      w_out = omega_lp;
      freq_acc = limit(freq_acc + rnd_shift(longint'(cfg_int) * vd, 23), FI_LO, FI_HI);
      // wrap test comes before the increment
      if (ang_acc >= TWO_PI_C) ang_acc -= TWO_PI_C;
      ang_acc += rnd_shift(w * longint'(cfg_step), 32);
      if (ang_acc < 0) ang_acc += TWO_PI_C;
      ang_acc = limit(ang_acc, 0, ANG_HI);
    end
    f.alpha_volt  = av[PU_W-1:0];
    f.beta_volt   = bv[PU_W-1:0];
    f.alpha_amp   = ai[PU_W-1:0];
    f.beta_amp    = bi[PU_W-1:0];
    f.direct_volt = vd[PU_W-1:0];
    f.quad_volt   = vq[PU_W-1:0];
    f.direct_amp  = id[PU_W-1:0];
    f.quad_amp    = iq[PU_W-1:0];
    f.sine_out    = sn[TRIG_W-1:0];
    f.cosine_out  = cs[TRIG_W-1:0];
    f.angle_out   = ang_out[ANGLE_W-1:0];
    f.omega_out   = w_out[OMEGA_W-1:0];
    return f;
  endfunction

  function automatic longint frame_field(frame_t f, int k);
    case (k)
      0:       return f.alpha_volt;
      1:       return f.beta_volt;
      2:       return f.alpha_amp;
      3:       return f.beta_amp;
      4:       return f.direct_volt;
      5:       return f.quad_volt;
      6:       return f.direct_amp;
      7:       return f.quad_amp;
      8:       return f.sine_out;
      9:       return f.cosine_out;
      10:      return f.angle_out;
      default: return f.omega_out;
    endcase
  endfunction

  // ---------------------------------------------------------------- sample sets

  function automatic sample_t mk(int a, b, c, ia, ib, ic, se, ce, bit st);
    sample_t s;
    s.volt_a = 16'(a);
    s.volt_b = 16'(b);
    s.volt_c = 16'(c);
    s.amp_a = 16'(ia);
    s.amp_b = 16'(ib);
    s.amp_c = 16'(ic);
    s.sine_ext = 16'(se);
    s.cosine_ext = 16'(ce);
    s.start_ac = st;
    return s;
  endfunction

  function automatic sample_t noise_sample();
    return mk($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom(), 1'($urandom()));
  endfunction

  // Balanced three-phase set; current lags voltage by lag
  function automatic sample_t wave_sample(longint pk_v, pk_i, logic [31:0] ph, lag);
    sample_t s;
    s.volt_a = 16'(rnd_shift(pk_v * turn_sine(ph), 14));
    s.volt_b = 16'(rnd_shift(pk_v * turn_sine(ph - THIRD_TURN), 14));
    s.volt_c = 16'(rnd_shift(pk_v * turn_sine(ph + THIRD_TURN), 14));
    s.amp_a = 16'(rnd_shift(pk_i * turn_sine(ph - lag), 14));
    s.amp_b = 16'(rnd_shift(pk_i * turn_sine(ph - lag - THIRD_TURN), 14));
    s.amp_c = 16'(rnd_shift(pk_i * turn_sine(ph - lag + THIRD_TURN), 14));
    s.sine_ext = 16'(turn_sine(ph));
    s.cosine_ext = 16'(turn_sine(ph + QUARTER_TURN));
    s.start_ac = 1'b0;
    return s;
  endfunction

  // Voltage lined up with the present angle, so V_d is close to pk
  function automatic sample_t aimed_sample(longint pk);
    return wave_sample(pk, pk, table_phase(ang_acc) + QUARTER_TURN, '0);
  endfunction

  function automatic logic [31:0] pick_setting(logic [31:0] dflt, top);
    case ($urandom_range(5))
      0:       return '0;
      1:       return top;
      2, 3:    return dflt;
      default: return $urandom() & top;
    endcase
  endfunction

  // ---------------------------------------------------------------- channels

  // Send one sample word, predict its result at acceptance
  task automatic send_sample(sample_t s);
    int gap;
    gap = 0;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) gap = $urandom_range(13, 1);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    volt_a <= s.volt_a;
    volt_b <= s.volt_b;
    volt_c <= s.volt_c;
    amp_a <= s.amp_a;
    amp_b <= s.amp_b;
    amp_c <= s.amp_c;
    sine_ext <= s.sine_ext;
    cosine_ext <= s.cosine_ext;
    start_ac <= s.start_ac;
    do @(posedge clk); while (!in_ready);
    pending_frames.push_back(predict_frame(s));
    sent++;
  endtask

  // Hold off input until every expected result word is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_frames.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE:      cfg_mode = data[1:0];
      REG_PROP_GAIN: cfg_prop = data[23:0];
      REG_INT_GAIN:  cfg_int = data[23:0];
      REG_STEP_TIME: cfg_step = data;
      REG_LPF_COEFF: cfg_lpf = data[15:0];
      REG_NOMINAL:   cfg_nom = data[26:0];
      default: ;
    endcase
  endtask

  // Idle the block, then write all registers
  task automatic configure(logic [1:0] m, logic [23:0] pg, logic [23:0] ig,
                           logic [31:0] st, logic [15:0] lc, logic [26:0] nom);
    drain_results();
    write_reg(REG_MODE, 32'(m));
    write_reg(REG_PROP_GAIN, 32'(pg));
    write_reg(REG_INT_GAIN, 32'(ig));
    write_reg(REG_STEP_TIME, st);
    write_reg(REG_LPF_COEFF, 32'(lc));
    write_reg(REG_NOMINAL, 32'(nom));
    cfg_valid <= 1'b0;
  endtask

  // Result side stalls in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      stall_left = $urandom_range(12, 0);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    frame_t got, want;
    int     k;
    if (!rst && out_valid && out_ready) begin
      got.alpha_volt  = alpha_volt;
      got.beta_volt   = beta_volt;
      got.alpha_amp   = alpha_amp;
      got.beta_amp    = beta_amp;
      got.direct_volt = direct_volt;
      got.quad_volt   = quad_volt;
      got.direct_amp  = direct_amp;
      got.quad_amp    = quad_amp;
      got.sine_out    = sine_out;
      got.cosine_out  = cosine_out;
      got.angle_out   = angle_out;
      got.omega_out   = omega_out;
      checked++;
      if (pending_frames.size() == 0) begin
        fail_count++;
        if (shown < 10) begin
          shown++;
          $display("result word %0d arrived with none expected", checked);
        end
      end else begin
        want = pending_frames.pop_front();
        for (k = 0; k < 12; k++) begin
          if (frame_field(got, k) != frame_field(want, k)) begin
            fail_count++;
            if (shown < 10) begin
              shown++;
              $display("word %0d %s: expected %0d, got %0d", checked, field_names[k],
                       frame_field(want, k), frame_field(got, k));
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Clarke extremes at reset settings
  task automatic test_clarke_extremes();
    configure(MODE_TRACK, DEF_PROP, DEF_INT, DEF_STEP, DEF_LPF, DEF_NOM);
    send_sample(mk(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_sample(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b1));
    send_sample(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 1'b0));
    send_sample(mk(32767, -32768, -32768, -32768, 32767, 32767, 0, 0, 1'b0));
    send_sample(mk(-32768, 32767, 32767, 32767, -32768, -32768, 0, 0, 1'b1));
    send_sample(mk(0, 32767, -32768, 0, -32768, 32767, 0, 0, 1'b0));
    send_sample(mk(0, -32768, 32767, 0, 32767, -32768, 0, 0, 1'b0));
  endtask

  // Fixed frequency, spare code, external angle with integrator clear
  task automatic test_operating_modes();
    configure(MODE_FIXED, DEF_PROP, DEF_INT, 32'hFFFF_FFFF, DEF_LPF, 27'h7FF_FFFF);
    send_sample(noise_sample());
    send_sample(noise_sample());
    configure(MODE_SPARE, DEF_PROP, DEF_INT, DEF_STEP, DEF_LPF, DEF_NOM);
    send_sample(mk(20000, -10000, -10000, 5000, 3000, -8000, 0, 0, 1'b1));
    send_sample(noise_sample());
    configure(MODE_EXT, DEF_PROP, 24'hFF_FFFF, DEF_STEP, DEF_LPF, DEF_NOM);
    send_sample(mk(16000, -8000, -8000, 9000, -4500, -4500, 11585, 11585, 1'b0));
    send_sample(mk(16000, -8000, -8000, 9000, -4500, -4500, 11585, 11585, 1'b1));
    send_sample(mk(-16000, 8000, 8000, -9000, 4500, 4500, -16384, 0, 1'b0));
  endtask

  // External sine and cosine past full scale
  task automatic test_external_limits();
    send_sample(mk(12000, -6000, -6000, 7000, 0, -7000, 32767, -32768, 1'b0));
    send_sample(mk(-12000, 6000, 6000, -7000, 0, 7000, -32768, 32767, 1'b0));
    send_sample(mk(30000, -15000, -15000, 0, 0, 0, 16385, -16385, 1'b0));
    send_sample(mk(30000, -15000, -15000, 0, 0, 0, 16384, -16384, 1'b0));
  endtask

  // Angle clamps at both ends and the wrap of a negative angle
  task automatic test_angle_limits();
    send_sample(mk(1000, -500, -500, 0, 0, 0, 0, 16384, 1'b1));
    configure(MODE_TRACK, 24'hFF_FFFF, 24'd0, 32'hFFFF_FFFF, DEF_LPF, DEF_NOM);
    send_sample(aimed_sample(-32767));
    send_sample(aimed_sample(32767));
    configure(MODE_TRACK, DEF_PROP, 24'd0, 32'hFFFF_FFFF, DEF_LPF, DEF_NOM);
    send_sample(aimed_sample(-32767));
    send_sample(aimed_sample(32767));
  endtask

  // Mostly grid-like waves with random content, some noise
  task automatic run_samples(int n, int pct, bit pause_midway);
    logic [31:0] ph, step, lag;
    longint      pk_v, pk_i;
    sample_t     s;
    int          i;
    idle_pct = pct;
    pk_v = $urandom_range(32767);
    pk_i = $urandom_range(32767);
    step = GRID_STEP + $urandom_range(8589934) - 32'd4294967;
    lag = $urandom();
    ph = $urandom();
    for (i = 0; i < n; i++) begin
      if ($urandom_range(9) < 2) begin
        s = noise_sample();
      end else begin
        s = wave_sample(pk_v, pk_i, ph, lag);
        if (cfg_mode == MODE_EXT) s.start_ac = (i < 3) || ($urandom_range(32) == 0);
        else s.start_ac = 1'($urandom());
      end
      ph += step;
      send_sample(s);
      if (pause_midway && i == n / 2) drain_results();
    end
  endtask

  // Register sweeps: all minimum, all maximum, random picks, reset values
  task automatic test_random_sweep();
    logic [1:0] modes [8];
    int         pcts [8];
    int         p;
    modes = '{MODE_FIXED, MODE_TRACK, MODE_EXT, MODE_TRACK, MODE_SPARE, MODE_EXT,
              MODE_FIXED, MODE_TRACK};
    pcts = '{20, 45, 0, 30, 10, 50, 25, 0};
    for (p = 0; p < 8; p++) begin
      if (p == 0)
        configure(modes[p], '0, '0, '0, '0, '0);
      else if (p == 1)
        configure(modes[p], 24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 27'h7FF_FFFF);
      else if (p == 7)
        configure(modes[p], DEF_PROP, DEF_INT, DEF_STEP, DEF_LPF, DEF_NOM);
      else
        configure(modes[p], pick_setting(DEF_PROP, 32'hFF_FFFF),
                  pick_setting(DEF_INT, 32'hFF_FFFF), pick_setting(DEF_STEP, 32'hFFFF_FFFF),
                  pick_setting(DEF_LPF, 32'hFFFF), pick_setting(DEF_NOM, 32'h7FF_FFFF));
      run_samples(104, pcts[p], p == 3);
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_clarke_extremes();
    test_operating_modes();
    test_external_limits();
    test_angle_limits();
    test_random_sweep();
    drain_results();
    repeat (40) @(posedge clk);
    $display("%0d sample words sent, %0d result words checked across all modes,",
             sent, checked);
    $display("angle clamps and wrap, external trig limits and register extremes");
    if (fail_count == 0 && pending_frames.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
